FILE: sv/d2qmc_pkg.sv
// Shared constants, types and arithmetic helpers for the D2Q9 moment collision core.
package d2qmc_pkg;

  localparam int QF       = 28;
  localparam int RF       = 30;
  localparam int N_DIST   = 9;
  localparam int DIST_W   = 32;
  localparam int DATA_W   = N_DIST * DIST_W;
  localparam int RATE_W   = 32;
  localparam int VAL_W    = 41;
  localparam int MAG_W    = VAL_W - 1;
  localparam int HALF_W   = MAG_W / 2;
  localparam int PROD_W   = 2 * MAG_W + 1;
  localparam int MOM_W    = 37;
  localparam int WIDE_W   = 46;
  localparam int DEN_W    = 35;
  localparam int OVF_SH   = MAG_W - QF;
  localparam int DIV_BPS  = 2;
  localparam int DIV_ST   = MAG_W / DIV_BPS;
  localparam int N_RLX    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int DIV3_SH  = 38;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic signed [MOM_W-1:0]  mom_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic        [DEN_W-1:0]  den_t;
  typedef logic        [RATE_W-1:0] rate_t;
  typedef val_t [N_RLX-1:0] vset_t;   // entry i belongs to moment i+3

  localparam logic [CFG_IDX_W-1:0] REG_BULK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR = 1'd1;

  localparam rate_t RATE_BULK_RST  = 32'd505798971;
  localparam rate_t RATE_SHEAR_RST = 32'd2147293220;

  localparam mag_t  IMAX    = '1;
  localparam val_t  VMAX    = {1'b0, IMAX};
  localparam wide_t WMAX    = wide_t'(VMAX);
  localparam val_t  THIRD_Q = 41'sd89478485;
  localparam wide_t OUT_MAX = 46'sd2147483647;
  localparam wide_t OUT_MIN = -OUT_MAX - 46'sd1;
  // (2^38 + 2) / 3: exact floor of x/3 for every x below 2^37
  localparam mag_t  DIV3_M  = 40'd91625968982;

  // Four 20x20 partial products of a sign-magnitude multiply
  typedef struct packed {
    logic neg;
    mag_t hh;
    mag_t hl;
    mag_t lh;
    mag_t ll;
  } pp_t;

  typedef struct packed {
    den_t       rem_u;
    den_t       rem_v;
    mag_t       low_u;
    mag_t       low_v;
    mag_t       q_u;
    mag_t       q_v;
    logic       ovf_u;
    logic       ovf_v;
    logic       neg_u;
    logic       neg_v;
  } div_t;

  typedef struct packed {
    logic                           inv;
    logic [N_DIST-1:0][DIST_W-1:0]  p;
    mom_t [N_DIST-1:0]              m;
  } ctx_t;

  function automatic val_t sat_val(wide_t x);
    if (x > WMAX) return VMAX;
    if (x < -WMAX) return -VMAX;
    return VAL_W'(x);
  endfunction

  function automatic pp_t mul_pp(val_t a, val_t b);
    pp_t  x;
    mag_t ma;
    mag_t mb;
    x.neg = a[VAL_W-1] ^ b[VAL_W-1];
    ma = a[VAL_W-1] ? MAG_W'(-a) : MAG_W'(a);
    mb = b[VAL_W-1] ? MAG_W'(-b) : MAG_W'(b);
    x.hh = ma[MAG_W-1:HALF_W] * mb[MAG_W-1:HALF_W];
    x.hl = ma[MAG_W-1:HALF_W] * mb[HALF_W-1:0];
    x.lh = ma[HALF_W-1:0] * mb[MAG_W-1:HALF_W];
    x.ll = ma[HALF_W-1:0] * mb[HALF_W-1:0];
    return x;
  endfunction

  // Sum partial products, drop fraction bits (Q.28 or Q.30 rate), saturate, sign
  function automatic val_t mul_fin(pp_t x, logic rate_q);
    logic [PROD_W-1:0]    tot;
    logic [PROD_W-QF-1:0] r;
    val_t                 v;
    tot = (PROD_W'(x.hh) << MAG_W) + ((PROD_W'(x.hl) + PROD_W'(x.lh)) << HALF_W)
          + PROD_W'(x.ll);
    r = rate_q ? (PROD_W-QF)'(tot >> RF) : (PROD_W-QF)'(tot >> QF);
    v = (r > (PROD_W-QF)'(IMAX)) ? VMAX : val_t'({1'b0, r[MAG_W-1:0]});
    return x.neg ? -v : v;
  endfunction

  // Sum partial products of x * DIV3_M and keep the integer quotient x/3
  function automatic mag_t div3_fin(pp_t x);
    logic [PROD_W-1:0] tot;
    tot = (PROD_W'(x.hh) << MAG_W) + ((PROD_W'(x.hl) + PROD_W'(x.lh)) << HALF_W)
          + PROD_W'(x.ll);
    return MAG_W'(tot >> DIV3_SH);
  endfunction

  // One restoring quotient bit for both velocity lanes
  function automatic div_t div_step(div_t d, den_t den);
    div_t             r;
    logic [DEN_W:0]   tu;
    logic [DEN_W:0]   tv;
    logic             bu;
    logic             bv;
    r  = d;
    tu = {d.rem_u, d.low_u[MAG_W-1]};
    tv = {d.rem_v, d.low_v[MAG_W-1]};
    bu = (tu >= {1'b0, den});
    bv = (tv >= {1'b0, den});
    r.rem_u = bu ? DEN_W'(tu - {1'b0, den}) : tu[DEN_W-1:0];
    r.rem_v = bv ? DEN_W'(tv - {1'b0, den}) : tv[DEN_W-1:0];
    r.low_u = d.low_u << 1;
    r.low_v = d.low_v << 1;
    r.q_u   = {d.q_u[MAG_W-2:0], bu};
    r.q_v   = {d.q_v[MAG_W-2:0], bv};
    return r;
  endfunction

  function automatic val_t div_out(logic ovf, logic neg, mag_t q);
    val_t v;
    v = ovf ? VMAX : val_t'({1'b0, q});
    return neg ? -v : v;
  endfunction

  function automatic logic [DIST_W-1:0] out_sat(wide_t x);
    if (x > OUT_MAX) return OUT_MAX[DIST_W-1:0];
    if (x < OUT_MIN) return OUT_MIN[DIST_W-1:0];
    return x[DIST_W-1:0];
  endfunction

endpackage

FILE: sv/d2q9_moment_collision_core.sv
// D2Q9 multiple-relaxation collision core: moments, relaxation and back map, fully pipelined.
//
// One lattice cell (nine Q4.28 populations) enters per clock unless the output is stalled,
// so throughput is one cell per cycle while m_tready keeps up. The pipeline is the velocity
// divider (20 stages, two quotient bits each, after a moment stage and a divider setup
// stage) followed by four multiply rounds of two stages each and the add, back-map and
// output stages. The whole pipeline holds when the output is stalled, so nothing is lost
// or repeated. A cell whose density is zero or negative leaves unchanged with tuser set.
// Rates are written through the cfg port (index 0 bulk, index 1 shear, unsigned Q2.30)
// and must only be changed while no cell is in flight.
module d2q9_moment_collision_core (
  input  logic                              clk,
  input  logic                              rst,
  // dist_rest, dist_east, dist_north, dist_west, dist_south, dist_northeast,
  // dist_northwest, dist_southwest, dist_southeast (32 bits each, lowest first)
  input  logic [d2qmc_pkg::DATA_W-1:0]      s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // out_rest, out_east, out_north, out_west, out_south, out_northeast,
  // out_northwest, out_southwest, out_southeast (32 bits each, lowest first)
  output logic [d2qmc_pkg::DATA_W-1:0]      m_tdata,
  // density_invalid
  output logic                              m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [d2qmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [d2qmc_pkg::RATE_W-1:0]      cfg_data
);

  localparam int ST_DIV0 = 1;
  localparam int ST_DIVN = ST_DIV0 + d2qmc_pkg::DIV_ST;
  localparam int ST_M1A  = ST_DIVN + 1;
  localparam int ST_M1B  = ST_M1A + 1;
  localparam int ST_EQ1  = ST_M1B + 1;
  localparam int ST_M2A  = ST_EQ1 + 1;
  localparam int ST_M2B  = ST_M2A + 1;
  localparam int ST_M3A  = ST_M2B + 1;
  localparam int ST_M3B  = ST_M3A + 1;
  localparam int ST_DIF  = ST_M3B + 1;
  localparam int ST_M4A  = ST_DIF + 1;
  localparam int ST_M4B  = ST_M4A + 1;
  localparam int ST_NEW  = ST_M4B + 1;
  localparam int ST_SUM  = ST_NEW + 1;
  localparam int ST_OUT  = ST_SUM + 1;

  logic                     adv;
  logic [0:ST_OUT]          vld;
  d2qmc_pkg::ctx_t          ctx [0:ST_SUM];
  d2qmc_pkg::ctx_t          ctx_next;
  d2qmc_pkg::rate_t         rate_bulk;
  d2qmc_pkg::rate_t         rate_shear;

  logic [d2qmc_pkg::N_DIST-1:0][d2qmc_pkg::DIST_W-1:0] pin;
  d2qmc_pkg::mom_t          pe [d2qmc_pkg::N_DIST];

  d2qmc_pkg::div_t          dv [0:d2qmc_pkg::DIV_ST];
  d2qmc_pkg::div_t          dv_init;
  d2qmc_pkg::den_t          mag_u;
  d2qmc_pkg::den_t          mag_v;
  d2qmc_pkg::den_t          den0;

  d2qmc_pkg::pp_t           pp1 [5];
  d2qmc_pkg::val_t          r1 [5];
  d2qmc_pkg::pp_t           third_a;
  d2qmc_pkg::mag_t          third_b;
  d2qmc_pkg::val_t          cu_a;
  d2qmc_pkg::val_t          cv_a;
  d2qmc_pkg::val_t          cv_b;
  d2qmc_pkg::val_t          cv_c;
  d2qmc_pkg::vset_t         eq_a;
  d2qmc_pkg::vset_t         eq_b;
  d2qmc_pkg::vset_t         eq_c;
  d2qmc_pkg::vset_t         eq_d;
  d2qmc_pkg::vset_t         eq_e;
  d2qmc_pkg::pp_t           pp2 [3];
  d2qmc_pkg::val_t          m0cu_c;
  d2qmc_pkg::pp_t           pp3;
  d2qmc_pkg::vset_t         dif;
  d2qmc_pkg::pp_t           pp4 [d2qmc_pkg::N_RLX];
  d2qmc_pkg::vset_t         prd;
  d2qmc_pkg::vset_t         mnew;
  d2qmc_pkg::wide_t         sums [d2qmc_pkg::N_DIST];
  d2qmc_pkg::wide_t         wm [d2qmc_pkg::N_DIST];
  logic [d2qmc_pkg::N_DIST-1:0][d2qmc_pkg::DIST_W-1:0] res;
  d2qmc_pkg::wide_t         qt;

  // Whole pipeline moves together unless the output register holds an untaken result
  assign adv       = !vld[ST_OUT] || m_tready;
  assign s_tready  = adv;
  assign m_tvalid  = vld[ST_OUT];
  assign cfg_ready = 1'b1;

  // Rate registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_bulk  <= d2qmc_pkg::RATE_BULK_RST;
      rate_shear <= d2qmc_pkg::RATE_SHEAR_RST;
    end else if (cfg_valid) begin
      if (cfg_index == d2qmc_pkg::REG_BULK) begin
        rate_bulk <= cfg_data;
      end else if (cfg_index == d2qmc_pkg::REG_SHEAR) begin
        rate_shear <= cfg_data;
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= ST_OUT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Raw moments of the incoming cell
  assign pin = s_tdata;
  always_comb begin
    for (int i = 0; i < d2qmc_pkg::N_DIST; i++) begin
      pe[i] = d2qmc_pkg::mom_t'(signed'(pin[i]));
    end
    ctx_next.p    = pin;
    ctx_next.m[0] = pe[0] + pe[1] + pe[2] + pe[3] + pe[4] + pe[5] + pe[6] + pe[7] + pe[8];
    ctx_next.m[1] = pe[1] - pe[3] + pe[5] - pe[6] - pe[7] + pe[8];
    ctx_next.m[2] = pe[2] - pe[4] + pe[5] + pe[6] - pe[7] - pe[8];
    ctx_next.m[3] = pe[1] + pe[2] + pe[3] + pe[4]
                    + ((pe[5] + pe[6] + pe[7] + pe[8]) <<< 1);
    ctx_next.m[4] = pe[5] - pe[6] - pe[7] + pe[8];
    ctx_next.m[5] = pe[5] + pe[6] - pe[7] - pe[8];
    ctx_next.m[6] = pe[5] + pe[6] + pe[7] + pe[8];
    ctx_next.m[7] = pe[1] - pe[2] + pe[3] - pe[4];
    ctx_next.m[8] = pe[5] - pe[6] + pe[7] - pe[8];
    ctx_next.inv  = ctx_next.m[0][d2qmc_pkg::MOM_W-1] || (ctx_next.m[0] == '0);
  end

  // Cell context shift line
  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0] <= ctx_next;
      for (int k = 1; k <= ST_SUM; k++) begin
        ctx[k] <= ctx[k-1];
      end
    end
  end

  // Divider setup: magnitudes, overflow test, leading remainder
  always_comb begin
    den0  = ctx[0].m[0][d2qmc_pkg::DEN_W-1:0];
    mag_u = ctx[0].m[1][d2qmc_pkg::MOM_W-1] ? d2qmc_pkg::DEN_W'(-ctx[0].m[1])
                                             : d2qmc_pkg::DEN_W'(ctx[0].m[1]);
    mag_v = ctx[0].m[2][d2qmc_pkg::MOM_W-1] ? d2qmc_pkg::DEN_W'(-ctx[0].m[2])
                                             : d2qmc_pkg::DEN_W'(ctx[0].m[2]);
    dv_init.ovf_u = (d2qmc_pkg::DEN_W+d2qmc_pkg::OVF_SH)'(mag_u)
                    >= {den0, d2qmc_pkg::OVF_SH'(0)};
    dv_init.ovf_v = (d2qmc_pkg::DEN_W+d2qmc_pkg::OVF_SH)'(mag_v)
                    >= {den0, d2qmc_pkg::OVF_SH'(0)};
    dv_init.neg_u = ctx[0].m[1][d2qmc_pkg::MOM_W-1];
    dv_init.neg_v = ctx[0].m[2][d2qmc_pkg::MOM_W-1];
    dv_init.rem_u = mag_u >> d2qmc_pkg::OVF_SH;
    dv_init.rem_v = mag_v >> d2qmc_pkg::OVF_SH;
    dv_init.low_u = d2qmc_pkg::MAG_W'(mag_u) << d2qmc_pkg::QF;
    dv_init.low_v = d2qmc_pkg::MAG_W'(mag_v) << d2qmc_pkg::QF;
    dv_init.q_u   = '0;
    dv_init.q_v   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv_init;
    end
  end

  // Divider stages, two quotient bits per stage
  for (genvar j = 1; j <= d2qmc_pkg::DIV_ST; j++) begin : g_div
    d2qmc_pkg::div_t dn;
    always_comb begin
      dn = dv[j-1];
      for (int b = 0; b < d2qmc_pkg::DIV_BPS; b++) begin
        dn = d2qmc_pkg::div_step(dn, ctx[ST_DIV0+j-1].m[0][d2qmc_pkg::DEN_W-1:0]);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j] <= dn;
      end
    end
  end

  // Multiply rounds, equilibria and relaxation
  always_ff @(posedge clk) begin
    if (adv) begin
      // round one: u*u, v*v, m1*u, m2*v, m1*v
      pp1[0]  <= d2qmc_pkg::mul_pp(
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_u, dv[d2qmc_pkg::DIV_ST].neg_u,
                                      dv[d2qmc_pkg::DIV_ST].q_u),
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_u, dv[d2qmc_pkg::DIV_ST].neg_u,
                                      dv[d2qmc_pkg::DIV_ST].q_u));
      pp1[1]  <= d2qmc_pkg::mul_pp(
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_v, dv[d2qmc_pkg::DIV_ST].neg_v,
                                      dv[d2qmc_pkg::DIV_ST].q_v),
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_v, dv[d2qmc_pkg::DIV_ST].neg_v,
                                      dv[d2qmc_pkg::DIV_ST].q_v));
      pp1[2]  <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_DIVN].m[1]),
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_u, dv[d2qmc_pkg::DIV_ST].neg_u,
                                      dv[d2qmc_pkg::DIV_ST].q_u));
      pp1[3]  <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_DIVN].m[2]),
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_v, dv[d2qmc_pkg::DIV_ST].neg_v,
                                      dv[d2qmc_pkg::DIV_ST].q_v));
      pp1[4]  <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_DIVN].m[1]),
                   d2qmc_pkg::div_out(dv[d2qmc_pkg::DIV_ST].ovf_v, dv[d2qmc_pkg::DIV_ST].neg_v,
                                      dv[d2qmc_pkg::DIV_ST].q_v));
      // 2*m0/3 by reciprocal multiply, split like the other products
      third_a <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_DIVN].m[0]) <<< 1,
                                   d2qmc_pkg::val_t'({1'b0, d2qmc_pkg::DIV3_M}));

      for (int i = 0; i < 5; i++) begin
        r1[i] <= d2qmc_pkg::mul_fin(pp1[i], 1'b0);
      end
      third_b <= d2qmc_pkg::div3_fin(third_a);

      // speed terms and the equilibria that need no further product
      cu_a    <= d2qmc_pkg::sat_val(d2qmc_pkg::wide_t'(d2qmc_pkg::THIRD_Q)
                                    + d2qmc_pkg::wide_t'(r1[0]));
      cv_a    <= d2qmc_pkg::sat_val(d2qmc_pkg::wide_t'(d2qmc_pkg::THIRD_Q)
                                    + d2qmc_pkg::wide_t'(r1[1]));
      eq_a    <= {r1[4],
                  d2qmc_pkg::sat_val(d2qmc_pkg::wide_t'(r1[2]) - d2qmc_pkg::wide_t'(r1[3])),
                  d2qmc_pkg::val_t'(0), d2qmc_pkg::val_t'(0), d2qmc_pkg::val_t'(0),
                  d2qmc_pkg::sat_val(d2qmc_pkg::wide_t'(r1[2]) + d2qmc_pkg::wide_t'(r1[3])
                                     + d2qmc_pkg::wide_t'({1'b0, third_b}))};

      // round two: m1*cv, m2*cu, m0*cu
      pp2[0]  <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_EQ1].m[1]), cv_a);
      pp2[1]  <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_EQ1].m[2]), cu_a);
      pp2[2]  <= d2qmc_pkg::mul_pp(d2qmc_pkg::val_t'(ctx[ST_EQ1].m[0]), cu_a);
      cv_b    <= cv_a;
      eq_b    <= eq_a;

      eq_c    <= {eq_b[5], eq_b[4], eq_b[3],
                  d2qmc_pkg::mul_fin(pp2[1], 1'b0),
                  d2qmc_pkg::mul_fin(pp2[0], 1'b0),
                  eq_b[0]};
      m0cu_c  <= d2qmc_pkg::mul_fin(pp2[2], 1'b0);
      cv_c    <= cv_b;

      // round three: (m0*cu)*cv
      pp3     <= d2qmc_pkg::mul_pp(m0cu_c, cv_c);
      eq_d    <= eq_c;

      eq_e    <= {eq_d[5], eq_d[4], d2qmc_pkg::mul_fin(pp3, 1'b0),
                  eq_d[2], eq_d[1], eq_d[0]};

      // distance to equilibrium, rate product, relaxed moment
      for (int i = 0; i < d2qmc_pkg::N_RLX; i++) begin
        dif[i]  <= d2qmc_pkg::sat_val(d2qmc_pkg::wide_t'(eq_e[i])
                                      - d2qmc_pkg::wide_t'(ctx[ST_M3B].m[i+3]));
        pp4[i]  <= d2qmc_pkg::mul_pp(dif[i],
                     d2qmc_pkg::val_t'({(d2qmc_pkg::VAL_W-d2qmc_pkg::RATE_W)'(0),
                                        (i < 4) ? rate_bulk : rate_shear}));
        prd[i]  <= d2qmc_pkg::mul_fin(pp4[i], 1'b1);
        mnew[i] <= d2qmc_pkg::sat_val(d2qmc_pkg::wide_t'(ctx[ST_M4B].m[i+3])
                                      + d2qmc_pkg::wide_t'(prd[i]));
      end
    end
  end

  // Back map to populations (before the quarter)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wm[i] = d2qmc_pkg::wide_t'(ctx[ST_NEW].m[i]);
    end
    for (int i = 0; i < d2qmc_pkg::N_RLX; i++) begin
      wm[i+3] = d2qmc_pkg::wide_t'(mnew[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sums[0] <= wm[0] - wm[3] + wm[6];
      sums[1] <= (wm[1] <<< 1) + wm[3] - (wm[4] <<< 1) - (wm[6] <<< 1) + wm[7];
      sums[2] <= (wm[2] <<< 1) + wm[3] - (wm[5] <<< 1) - (wm[6] <<< 1) - wm[7];
      sums[3] <= -(wm[1] <<< 1) + wm[3] + (wm[4] <<< 1) - (wm[6] <<< 1) + wm[7];
      sums[4] <= -(wm[2] <<< 1) + wm[3] + (wm[5] <<< 1) - (wm[6] <<< 1) - wm[7];
      sums[5] <= wm[4] + wm[5] + wm[6] + wm[8];
      sums[6] <= -wm[4] + wm[5] + wm[6] - wm[8];
      sums[7] <= -wm[4] - wm[5] + wm[6] + wm[8];
      sums[8] <= wm[4] - wm[5] + wm[6] - wm[8];
    end
  end

  // Quarter toward zero (all but the rest population), saturate to 32 bits
  always_comb begin
    qt     = sums[0];
    res[0] = d2qmc_pkg::out_sat(sums[0]);
    for (int i = 1; i < d2qmc_pkg::N_DIST; i++) begin
      qt     = sums[i][d2qmc_pkg::WIDE_W-1] ? ((sums[i] + d2qmc_pkg::wide_t'(3)) >>> 2)
                                            : (sums[i] >>> 2);
      res[i] = d2qmc_pkg::out_sat(qt);
    end
  end

  // Output register; pass the cell through on bad density
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= ctx[ST_SUM].inv ? ctx[ST_SUM].p : res;
      m_tuser <= ctx[ST_SUM].inv;
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_DIVN] && !ctx[ST_DIVN].inv && !dv[d2qmc_pkg::DIV_ST].ovf_u |->
      dv[d2qmc_pkg::DIV_ST].rem_u < ctx[ST_DIVN].m[0][d2qmc_pkg::DEN_W-1:0])
    else $error("velocity divider remainder not below density");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    vld[ST_SUM] && adv |=> m_tuser == $past(ctx[ST_SUM].inv))
    else $error("density flag does not follow the cell");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    vld[ST_SUM] && adv && ctx[ST_SUM].inv |=> m_tdata == $past(ctx[ST_SUM].p))
    else $error("bad-density cell not passed through");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[ST_SUM]))
    else $error("output valid without a cell in the last stage");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the D2Q9 moment collision core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIM = 64'sd1099511627775;
  localparam longint THIRD = 64'sd89478485;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [d2qmc_pkg::DATA_W-1:0] pops;
    logic                         invalid;
  } cell_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [d2qmc_pkg::DATA_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [d2qmc_pkg::DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [d2qmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [d2qmc_pkg::RATE_W-1:0] cfg_data = '0;

  d2qmc_pkg::rate_t bulk_rate = d2qmc_pkg::RATE_BULK_RST;
  d2qmc_pkg::rate_t shear_rate = d2qmc_pkg::RATE_SHEAR_RST;
  cell_t collided_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int invalid_seen = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int burst_left = 0;

  d2q9_moment_collision_core dut (.*);

  always #1 clk = ~clk;

  // Fixed-point helpers at the internal 41-bit saturation range
  function automatic longint clamp(longint x);
    if (x > LIM) return LIM;
    if (x < -LIM) return -LIM;
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh);
    logic [127:0] prod;
    longint       ua;
    longint       ub;
    longint       r;
    bit           neg;
    a = clamp(a);
    b = clamp(b);
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = (128'(ua) * 128'(ub)) >> sh;
    r = (prod > 128'(LIM)) ? LIM : longint'(prod);
    return neg ? -r : r;
  endfunction

  function automatic longint relax_to(longint cur, longint eq, d2qmc_pkg::rate_t s);
    return clamp(cur + fx_mul(clamp(eq - cur), longint'({32'd0, s}), d2qmc_pkg::RF));
  endfunction

  function automatic logic [31:0] to_q428(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // Collide one cell: moments, relaxation, back map
  function automatic cell_t collide(logic [d2qmc_pkg::DATA_W-1:0] d);
    cell_t  c;
    longint p[9];
    longint m[9];
    longint r[9];
    longint u, v, cu, cv, m1u, m2v;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(d[32*i +: 32]));
    m[0] = 0;
    for (int i = 0; i < 9; i++) m[0] += p[i];
    if (m[0] <= 0) begin
      c.pops = d;
      c.invalid = 1'b1;
      return c;
    end
    m[1] = p[1] - p[3] + p[5] - p[6] - p[7] + p[8];
    m[2] = p[2] - p[4] + p[5] + p[6] - p[7] - p[8];
    m[3] = p[1] + p[2] + p[3] + p[4] + 2 * (p[5] + p[6] + p[7] + p[8]);
    m[4] = p[5] - p[6] - p[7] + p[8];
    m[5] = p[5] + p[6] - p[7] - p[8];
    m[6] = p[5] + p[6] + p[7] + p[8];
    m[7] = p[1] - p[2] + p[3] - p[4];
    m[8] = p[5] - p[6] + p[7] - p[8];
    u = clamp((m[1] * 64'sd268435456) / m[0]);
    v = clamp((m[2] * 64'sd268435456) / m[0]);
    cu = clamp(THIRD + fx_mul(u, u, d2qmc_pkg::QF));
    cv = clamp(THIRD + fx_mul(v, v, d2qmc_pkg::QF));
    m1u = fx_mul(m[1], u, d2qmc_pkg::QF);
    m2v = fx_mul(m[2], v, d2qmc_pkg::QF);
    m[3] = relax_to(m[3], clamp(m1u + m2v + (2 * m[0]) / 3), bulk_rate);
    m[4] = relax_to(m[4], fx_mul(m[1], cv, d2qmc_pkg::QF), bulk_rate);
    m[5] = relax_to(m[5], fx_mul(m[2], cu, d2qmc_pkg::QF), bulk_rate);
    m[6] = relax_to(m[6], fx_mul(fx_mul(m[0], cu, d2qmc_pkg::QF), cv, d2qmc_pkg::QF),
                    bulk_rate);
    m[7] = relax_to(m[7], clamp(m1u - m2v), shear_rate);
    m[8] = relax_to(m[8], fx_mul(m[1], v, d2qmc_pkg::QF), shear_rate);
    r[0] = m[0] - m[3] + m[6];
    r[1] = (2 * m[1] + m[3] - 2 * m[4] - 2 * m[6] + m[7]) / 4;
    r[2] = (2 * m[2] + m[3] - 2 * m[5] - 2 * m[6] - m[7]) / 4;
    r[3] = (-2 * m[1] + m[3] + 2 * m[4] - 2 * m[6] + m[7]) / 4;
    r[4] = (-2 * m[2] + m[3] + 2 * m[5] - 2 * m[6] - m[7]) / 4;
    r[5] = (m[4] + m[5] + m[6] + m[8]) / 4;
    r[6] = (-m[4] + m[5] + m[6] - m[8]) / 4;
    r[7] = (-m[4] - m[5] + m[6] + m[8]) / 4;
    r[8] = (m[4] - m[5] + m[6] - m[8]) / 4;
    for (int i = 0; i < 9; i++) c.pops[32*i +: 32] = to_q428(r[i]);
    c.invalid = 1'b0;
    return c;
  endfunction

  // Send one cell, with bursts and random gaps between them; valid stays up inside a burst
  task automatic send_cell(logic [d2qmc_pkg::DATA_W-1:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    s_tdata <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    collided_q.push_back(collide(d));
    @(negedge clk);
  endtask

  // Write one rate; the caller drops cfg_valid after the last write
  task automatic write_rate(logic [d2qmc_pkg::CFG_IDX_W-1:0] idx, d2qmc_pkg::rate_t val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == d2qmc_pkg::REG_BULK) bulk_rate = val;
    else if (idx == d2qmc_pkg::REG_SHEAR) shear_rate = val;
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty before touching the rates
  task automatic drain();
    s_tvalid <= 1'b0;
    while (collided_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pop(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 32'h0800_0000)));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  // Random cell: mostly small populations with modest flow, sometimes full-range or extreme values
  function automatic logic [d2qmc_pkg::DATA_W-1:0] rand_cell();
    logic [d2qmc_pkg::DATA_W-1:0] d;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 6) d[32*i +: 32] = rand_pop(1);
      else if (kind < 8) d[32*i +: 32] = rand_pop(3);
      else if (kind == 8) d[32*i +: 32] = rand_pop(0);
      else d[32*i +: 32] = rand_pop($urandom_range(0, 3));
    end
    return d;
  endfunction

  task automatic test_directed();
    logic [d2qmc_pkg::DATA_W-1:0] d;
    send_cell('0);
    send_cell({9{32'h7fffffff}});
    send_cell({9{32'h80000000}});
    send_cell({9{32'hffffffff}});
    send_cell({9{32'h1000_0000}});
    // tiny density with strong momentum drives u and v to saturation
    d = '0;
    d[32*1 +: 32] = 32'h7fffffff;
    d[32*3 +: 32] = 32'h8000_0002;
    d[32*2 +: 32] = 32'h7fffffff;
    d[32*4 +: 32] = 32'h8000_0001;
    send_cell(d);
    d = '0;
    d[0 +: 32] = 32'd1;
    send_cell(d);
    for (int i = 0; i < 9; i++) begin
      d = '0;
      d[32*i +: 32] = 32'h7fffffff;
      send_cell(d);
    end
    d = {9{32'h0400_0000}};
    d[32*5 +: 32] = 32'h80000000;
    send_cell(d);
    for (int i = 0; i < 4; i++) begin
      send_cell({32'h5555_5555, {8{32'h2aaa_aaaa}}} ^ d2qmc_pkg::DATA_W'(i));
    end
  endtask

  task automatic test_rates(d2qmc_pkg::rate_t b, d2qmc_pkg::rate_t s, int n);
    drain();
    write_rate(d2qmc_pkg::REG_BULK, b);
    write_rate(d2qmc_pkg::REG_SHEAR, s);
    write_rate(~d2qmc_pkg::REG_SHEAR & d2qmc_pkg::REG_BULK, b);
    cfg_valid <= 1'b0;
    repeat (n) send_cell(rand_cell());
  endtask

  // Stall the output long enough to fill the pipeline and back up the input
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (120) send_cell(rand_cell());
    join
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else if (($time / 200) % 3 == 0) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Compare each collided cell with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (collided_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cell out: %h", m_tdata);
      end else begin
        cell_t e;
        e = collided_q.pop_front();
        if (e.invalid) invalid_seen++;
        if (e.pops !== m_tdata || e.invalid !== m_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp flag %0b data %h / got flag %0b data %h",
                     e.invalid, e.pops, m_tuser, m_tdata);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_rates(32'h8000_0000, 32'h0, 250);
    test_rates(32'h0, 32'h8000_0000, 200);
    test_rates(32'hffff_ffff, 32'h4000_0000, 150);
    test_rates($urandom(), $urandom(), 200);
    test_rates(d2qmc_pkg::RATE_BULK_RST, d2qmc_pkg::RATE_SHEAR_RST, 150);
    drain();
    $display("Covered %0d cells (%0d with non-positive density) across six rate settings,",
             results_seen, invalid_seen);
    $display("with bursty input, random output stalls and one long output hold-off.");
    if (mismatches == 0 && collided_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d cells missing", mismatches, collided_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/d2qmc_pkg.sv
sv/d2q9_moment_collision_core.sv
tb/sv/testbench.sv
